@@ hdl/tpd_pkg.sv @@
// Shared types, constants and arithmetic helpers for the touch packet decoder.
// No dependencies; the design files refer to this package by scope, the verification files import it.
package tpd_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned ProdW  = 2 * CoordW;

  localparam logic [7:0]        STATUS_MASK  = 8'h81;
  localparam logic [CoordW-1:0] RAW_CLAMP    = 12'd4095;
  localparam logic [CoordW-1:0] X_MAX_RESET  = 12'd479;
  localparam logic [CoordW-1:0] Y_MAX_RESET  = 12'd799;

  localparam int unsigned AddrW = 3;
  localparam logic REG_SCREEN_X_MAX = 1'b0;
  localparam logic REG_SCREEN_Y_MAX = 1'b1;

  typedef struct packed {
    logic              is_release;
    logic [CoordW-1:0] x_raw;
    logic [CoordW-1:0] y_raw;
  } tpd_job_t;

  typedef struct packed {
    logic full;
    logic valid;
  } tpd_qstat_t;

  function automatic logic [CoordW-1:0] tpd_clamp(input logic [6:0] lo7,
                                                   input logic [6:0] hi7);
    logic [13:0] raw;
    raw = {hi7, lo7};
    if (raw[13:12] != 2'b00) begin
      return RAW_CLAMP;
    end
    return raw[CoordW-1:0];
  endfunction

  // floor(p / 4095) for p below 4095*4096
  function automatic logic [CoordW-1:0] tpd_div4095(input logic [ProdW-1:0] p);
    logic [CoordW-1:0] q0;
    logic [CoordW:0]   r;
    q0 = p[ProdW-1:CoordW];
    r  = {1'b0, p[CoordW-1:0]} + {1'b0, q0};
    if (r >= {1'b0, RAW_CLAMP}) begin
      return q0 + 12'd1;
    end
    return q0;
  endfunction

endpackage

@@ hdl/tpd_if.sv @@
// Handshake channels of the touch packet decoder: received bytes and events.
// Depends on tpd_pkg for the coordinate width.
interface tpd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tpd_event_if;
  logic                         valid;
  logic                         ready;
  logic                         is_release;
  logic [tpd_pkg::CoordW-1:0]   x_pixel;
  logic [tpd_pkg::CoordW-1:0]   y_pixel;

  modport source (output valid, output is_release, output x_pixel, output y_pixel,
                  input ready);
  modport sink   (input valid, input is_release, input x_pixel, input y_pixel,
                  output ready);
endinterface

@@ hdl/tpd_front.sv @@
// Front end: accepts received bytes, tracks packet framing, clamps raw coordinates
// and pushes one job per complete packet. Depends on tpd_pkg and tpd_byte_if.
module tpd_front (
  input  logic                clk,
  input  logic                rst,
  tpd_byte_if.sink            rx,
  input  tpd_pkg::tpd_qstat_t qstat,
  output logic                push,
  output tpd_pkg::tpd_job_t   job
);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_XLO  = 5'b00010,
    PH_XHI  = 5'b00100,
    PH_YLO  = 5'b01000,
    PH_YHI  = 5'b10000
  } phase_t;

  phase_t                     phase, phase_next;
  logic                       kind;
  logic [6:0]                 low_seven;
  logic [tpd_pkg::CoordW-1:0] x_raw_held;
  logic                       take;

  assign rx.ready = (phase != PH_YHI) || !qstat.full;
  assign take     = rx.valid && rx.ready;
  assign push     = take && (phase == PH_YHI);

  assign job.is_release = kind;
  assign job.x_raw      = x_raw_held;
  assign job.y_raw      = tpd_pkg::tpd_clamp(low_seven, rx.rx_byte[6:0]);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_XLO: phase_next = PH_XHI;
      PH_XHI: phase_next = PH_YLO;
      PH_YLO: phase_next = PH_YHI;
      PH_YHI: phase_next = PH_IDLE;
      default: begin
        phase_next = rx.rx_byte[7] ? PH_XLO : PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      kind       <= 1'b0;
      low_seven  <= 7'd0;
      x_raw_held <= '0;
    end else if (take) begin
      phase <= phase_next;
      unique case (phase)
        PH_XLO, PH_YLO: low_seven <= rx.rx_byte[6:0];
        PH_XHI: x_raw_held <= tpd_pkg::tpd_clamp(low_seven, rx.rx_byte[6:0]);
        PH_YHI: ;
        default: begin
          if ((rx.rx_byte & tpd_pkg::STATUS_MASK) == tpd_pkg::STATUS_MASK) begin
            kind <= 1'b0;
          end else if (rx.rx_byte[7]) begin
            kind <= 1'b1;
          end
        end
      endcase
    end
  end

`ifndef SYNTH
  a_push_on_last_byte: assert property (@(posedge clk) disable iff (rst)
    (take && phase == PH_YHI) |-> push)
    else $error("last coordinate byte accepted without a job push");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("job pushed into a full queue");
  a_status_starts_packet: assert property (@(posedge clk) disable iff (rst)
    (take && phase == PH_IDLE && rx.rx_byte[7]) |=> (phase == PH_XLO))
    else $error("status byte did not start a packet");
`endif

endmodule

@@ hdl/tpd_queue.sv @@
// Two-entry job queue between the framing front end and the scaling back end.
// Depends on tpd_pkg for the job and status types.
module tpd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  tpd_pkg::tpd_job_t   push_job,
  input  logic                pop,
  output tpd_pkg::tpd_job_t   pop_job,
  output tpd_pkg::tpd_qstat_t qstat
);

  tpd_pkg::tpd_job_t mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;

  assign qstat.full  = (count == 2'd2);
  assign qstat.valid = (count != 2'd0);
  assign pop_job     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> qstat.valid)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("push without pop did not grow the queue");
`endif

endmodule

@@ hdl/tpd_back.sv @@
// Back end: pops jobs, multiplies raw coordinates by the screen limits, divides by
// 4095 and holds the event in an output register. Depends on tpd_pkg, tpd_event_if.
module tpd_back (
  input  logic                       clk,
  input  logic                       rst,
  input  tpd_pkg::tpd_qstat_t        qstat,
  input  tpd_pkg::tpd_job_t          job,
  output logic                       pop,
  input  logic [tpd_pkg::CoordW-1:0] screen_x_max,
  input  logic [tpd_pkg::CoordW-1:0] screen_y_max,
  tpd_event_if.source                evt
);

  logic                      m_valid;
  logic                      m_kind;
  logic [tpd_pkg::ProdW-1:0] m_px;
  logic [tpd_pkg::ProdW-1:0] m_py;
  logic                      o_valid;
  logic                      o_load_ok;
  logic                      m_load_ok;

  assign o_load_ok = !o_valid || evt.ready;
  assign m_load_ok = !m_valid || o_load_ok;
  assign pop       = qstat.valid && m_load_ok;
  assign evt.valid = o_valid;

  always_ff @(posedge clk) begin
    if (pop) begin
      m_kind <= job.is_release;
      m_px   <= job.x_raw * screen_x_max;
      m_py   <= job.y_raw * screen_y_max;
    end
    if (m_valid && o_load_ok) begin
      evt.is_release <= m_kind;
      evt.x_pixel    <= tpd_pkg::tpd_div4095(m_px);
      evt.y_pixel    <= tpd_pkg::tpd_div4095(m_py);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (m_load_ok) begin
        m_valid <= pop;
      end
      if (o_load_ok) begin
        o_valid <= m_valid;
      end
    end
  end

`ifndef SYNTH
  a_no_pop_while_blocked: assert property (@(posedge clk) disable iff (rst)
    (m_valid && o_valid && !evt.ready) |-> !pop)
    else $error("job popped while the back end is blocked");
  a_product_moves_on: assert property (@(posedge clk) disable iff (rst)
    (m_valid && o_load_ok) |=> o_valid)
    else $error("product stage advanced without filling the output register");
  a_evt_held: assert property (@(posedge clk) disable iff (rst)
    (evt.valid && !evt.ready)
      |=> (evt.valid && $stable(evt.x_pixel) && $stable(evt.y_pixel)))
    else $error("event changed while the sink stalls");
`endif

endmodule

@@ hdl/touch_packet_decoder_core.sv @@
// Touch packet decoder top level: scale registers on the APB port, front end,
// job queue and back end. Depends on tpd_pkg, tpd_if, tpd_front, tpd_queue, tpd_back.
//
// Usage:
//   rx carries one received controller byte per transaction. While idle, a byte with
//   bit 7 set opens a packet (bit 0 set: press, clear: release); the next four bytes
//   are x low, x high, y low, y high (seven bits each). Other idle bytes are dropped.
//   evt carries one event per packet: is_release, x_pixel and y_pixel, where each
//   pixel is min(raw,4095)*max/4095 truncated, using screen_x_max/screen_y_max.
//   The APB port writes screen_x_max at address 0 and screen_y_max at address 4.
//   A job passes the queue, the product stage (one multiply per coordinate) and the
//   output register to evt. Throughput: one byte per cycle while rx is ready, set by
//   the framing front end; the back end takes one event per cycle unless evt stalls.
//   A stalled evt fills the output register, the product stage and a two-entry job
//   queue; rx keeps taking bytes until a final packet byte finds the queue full.
//   Reset is synchronous: framing returns to idle, queue and stages empty, and the
//   scale registers return to 479 and 799.
module touch_packet_decoder_core (
  input  logic                        clk,
  input  logic                        rst,
  tpd_byte_if.sink                    rx,
  tpd_event_if.source                 evt,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpd_pkg::AddrW-1:0]   paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [tpd_pkg::CoordW-1:0] screen_x_max;
  logic [tpd_pkg::CoordW-1:0] screen_y_max;
  logic                       cfg_write;
  logic                       push;
  logic                       pop;
  tpd_pkg::tpd_job_t          push_job;
  tpd_pkg::tpd_job_t          pop_job;
  tpd_pkg::tpd_qstat_t        qstat;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      tpd_pkg::REG_SCREEN_X_MAX: prdata = {20'd0, screen_x_max};
      tpd_pkg::REG_SCREEN_Y_MAX: prdata = {20'd0, screen_y_max};
      default:                   prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_x_max <= tpd_pkg::X_MAX_RESET;
      screen_y_max <= tpd_pkg::Y_MAX_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        tpd_pkg::REG_SCREEN_X_MAX: screen_x_max <= pwdata[tpd_pkg::CoordW-1:0];
        tpd_pkg::REG_SCREEN_Y_MAX: screen_y_max <= pwdata[tpd_pkg::CoordW-1:0];
        default: ;
      endcase
    end
  end

  tpd_front u_front (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .qstat (qstat),
    .push  (push),
    .job   (push_job)
  );

  tpd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .qstat    (qstat)
  );

  tpd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .job          (pop_job),
    .pop          (pop),
    .screen_x_max (screen_x_max),
    .screen_y_max (screen_y_max),
    .evt          (evt)
  );

`ifndef SYNTH
  a_cfg_x_write: assert property (@(posedge clk) disable iff (rst)
    (cfg_write && paddr[2] == tpd_pkg::REG_SCREEN_X_MAX)
      |=> (screen_x_max == $past(pwdata[tpd_pkg::CoordW-1:0])))
    else $error("screen_x_max not updated by write");
  a_cfg_y_hold: assert property (@(posedge clk) disable iff (rst)
    !(cfg_write && paddr[2] == tpd_pkg::REG_SCREEN_Y_MAX) |=> $stable(screen_y_max))
    else $error("screen_y_max changed without a write");
  a_push_needs_byte: assert property (@(posedge clk) disable iff (rst)
    push |-> (rx.valid && rx.ready))
    else $error("job pushed without an accepted byte");
`endif

endmodule

@@ verif/tpd_checker.sv @@
`timescale 1ns / 1ps
// Event checker for the touch packet decoder: follows the byte, event and APB traffic,
// predicts each event from the accepted bytes and compares it field by field.
// Depends on tpd_pkg and the channel interfaces in tpd_if.
module tpd_checker
  import tpd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  tpd_byte_if                rx,
  tpd_event_if               evt,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic               pready,
  input  logic [AddrW-1:0]   paddr,
  input  logic [31:0]        pwdata,
  output int unsigned        fail_count,
  output int unsigned        events_pending
);

  typedef enum logic [2:0] {
    AWAIT_STATUS,
    AWAIT_X_LO,
    AWAIT_X_HI,
    AWAIT_Y_LO,
    AWAIT_Y_HI
  } frame_phase_t;

  typedef struct packed {
    logic              is_release;
    logic [CoordW-1:0] x_pixel;
    logic [CoordW-1:0] y_pixel;
  } touch_event_t;

  frame_phase_t      phase       = AWAIT_STATUS;
  logic              release_pkt = 1'b0;
  logic [6:0]        low_bits    = '0;
  logic [CoordW-1:0] x_clamped   = '0;
  logic [CoordW-1:0] x_span      = X_MAX_RESET;
  logic [CoordW-1:0] y_span      = Y_MAX_RESET;
  int unsigned       mismatches  = 0;
  touch_event_t      expected_events[$];

  function automatic logic [CoordW-1:0] clamped(input logic [6:0] lo, input logic [6:0] hi);
    logic [13:0] raw;
    raw = {hi, lo};
    return (raw > 14'(RAW_CLAMP)) ? RAW_CLAMP : raw[CoordW-1:0];
  endfunction

  function automatic logic [CoordW-1:0] scaled(input logic [CoordW-1:0] raw,
                                               input logic [CoordW-1:0] span);
    int unsigned prod;
    prod = 32'(raw) * 32'(span);
    return CoordW'(prod / 32'(RAW_CLAMP));
  endfunction

  task automatic report(input string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $time, what);
  endtask

  always @(posedge clk) begin
    touch_event_t seen;
    touch_event_t want;
    logic [7:0]   b;
    if (rst) begin
      phase       = AWAIT_STATUS;
      release_pkt = 1'b0;
      low_bits    = '0;
      x_clamped   = '0;
      x_span      = X_MAX_RESET;
      y_span      = Y_MAX_RESET;
      expected_events.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        if (paddr[AddrW-1:2] == REG_SCREEN_X_MAX) begin
          x_span = pwdata[CoordW-1:0];
        end
        if (paddr[AddrW-1:2] == REG_SCREEN_Y_MAX) begin
          y_span = pwdata[CoordW-1:0];
        end
      end

      if (rx.valid && rx.ready) begin
        b = rx.rx_byte;
        case (phase)
          AWAIT_X_LO: begin
            low_bits = b[6:0];
            phase    = AWAIT_X_HI;
          end
          AWAIT_X_HI: begin
            x_clamped = clamped(low_bits, b[6:0]);
            phase     = AWAIT_Y_LO;
          end
          AWAIT_Y_LO: begin
            low_bits = b[6:0];
            phase    = AWAIT_Y_HI;
          end
          AWAIT_Y_HI: begin
            want = '{is_release: release_pkt,
                     x_pixel:    scaled(x_clamped, x_span),
                     y_pixel:    scaled(clamped(low_bits, b[6:0]), y_span)};
            expected_events.push_back(want);
            phase = AWAIT_STATUS;
          end
          default: begin
            phase = AWAIT_STATUS;
            if ((b & STATUS_MASK) == STATUS_MASK) begin
              release_pkt = 1'b0;
              phase       = AWAIT_X_LO;
            end else if (b[7]) begin
              release_pkt = 1'b1;
              phase       = AWAIT_X_LO;
            end
          end
        endcase
      end

      if (evt.valid && evt.ready) begin
        seen = '{is_release: evt.is_release, x_pixel: evt.x_pixel, y_pixel: evt.y_pixel};
        if (expected_events.size() == 0) begin
          report($sformatf("unexpected event release=%0b x=%0d y=%0d",
                           seen.is_release, seen.x_pixel, seen.y_pixel));
        end else begin
          want = expected_events.pop_front();
          if (seen.is_release !== want.is_release) begin
            report($sformatf("is_release %0b, want %0b", seen.is_release, want.is_release));
          end
          if (seen.x_pixel !== want.x_pixel) begin
            report($sformatf("x_pixel %0d, want %0d", seen.x_pixel, want.x_pixel));
          end
          if (seen.y_pixel !== want.y_pixel) begin
            report($sformatf("y_pixel %0d, want %0d", seen.y_pixel, want.y_pixel));
          end
        end
      end
    end
    fail_count     <= mismatches;
    events_pending <= expected_events.size();
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for touch_packet_decoder_core: clock, reset, byte and APB stimulus,
// randomly stalling event sink, and the verdict. Depends on tpd_pkg, tpd_if, tpd_checker.
module tb;
  import tpd_pkg::*;

  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned SettleCycles = 12;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [AddrW-1:0]  paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int unsigned       fail_count;
  int unsigned       events_pending;
  bit                brisk;
  bit                hold_req;
  logic              evt_hold;

  logic [7:0] directed_bytes [23] = '{
    8'h81, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h7F, 8'h01,
    8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'h7F, 8'h1F, 8'h00, 8'h20,
    8'hFE, 8'h80, 8'hA0, 8'h81, 8'h9F
  };

  tpd_byte_if  rx();
  tpd_event_if evt();

  touch_packet_decoder_core dut (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .evt     (evt),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tpd_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .rx             (rx),
    .evt            (evt),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count     (fail_count),
    .events_pending (events_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned idle_gap();
    return brisk ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [13:0] pick_raw();
    case ($urandom_range(0, 7))
      0: return 14'd0;
      1: return 14'd4095;
      2: return 14'd4096;
      3: return 14'h3FFF;
      4, 5: return 14'($urandom_range(0, 4095));
      default: return 14'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = idle_gap();
    repeat (gap) begin
      rx.valid <= 1'b0;
      @(posedge clk);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
  endtask

  task automatic send_packet();
    logic [13:0] x_raw;
    logic [13:0] y_raw;
    x_raw = pick_raw();
    y_raw = pick_raw();
    send_byte({1'b1, 6'($urandom), 1'($urandom)});
    send_byte({1'($urandom), x_raw[6:0]});
    send_byte({1'($urandom), x_raw[13:7]});
    send_byte({1'($urandom), y_raw[6:0]});
    send_byte({1'($urandom), y_raw[13:7]});
  endtask

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_scale(input logic [CoordW-1:0] x_max, input logic [CoordW-1:0] y_max);
    apb_write({REG_SCREEN_X_MAX, 2'b00}, {20'($urandom), x_max});
    apb_write({REG_SCREEN_Y_MAX, 2'b00}, {20'($urandom), y_max});
  endtask

  // drain every pending event, then let the pipeline settle
  task automatic finish_phase();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (events_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned sent;
    int unsigned pick;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 39) == 0) brisk = !brisk;
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        send_packet();
        sent += 5;
      end else if (pick < 90) begin
        send_byte({1'b0, 7'($urandom)});
      end else begin
        send_byte(8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin : evt_sink
    int unsigned gap_left;
    gap_left  = 0;
    evt.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (evt.valid && evt.ready) gap_left = idle_gap();
      if (rst || evt_hold || gap_left != 0) begin
        evt.ready <= 1'b0;
        if (!rst && !evt_hold && gap_left != 0) gap_left--;
      end else begin
        evt.ready <= 1'b1;
      end
    end
  end

  initial begin : evt_hold_off
    evt_hold = 1'b0;
    wait (hold_req);
    @(posedge clk);
    evt_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    evt_hold <= 1'b0;
  end

  initial begin : run_limit
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    finish_phase();

    set_scale(12'd4095, 12'd4095);
    random_phase(200);
    finish_phase();

    set_scale(12'd1, 12'd1);
    random_phase(150);
    finish_phase();

    set_scale(12'd0, 12'd0);
    random_phase(100);
    finish_phase();

    set_scale(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
    brisk    = 1'b1;
    hold_req = 1'b1;
    random_phase(250);
    finish_phase();

    set_scale(12'd4095, 12'd1);
    random_phase(200);
    finish_phase();

    set_scale(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)));
    random_phase(300);
    finish_phase();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
